/* hdl/crse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crse_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int IDX_W       = 6;
	localparam int BANKS       = 4;
	localparam int BANK_SEL_W  = 2;
	localparam int BANK_DEPTH  = MAX_POINTS / BANKS;
	localparam int BANK_AW     = 4;
	localparam int COORD_W     = 16;
	localparam int ENTRY_W     = 2 * COORD_W;
	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = 17;
	localparam int TT_W        = 18;
	localparam int TTT_W       = 19;
	localparam int WGT_W       = 24;
	localparam int PROD_W      = COORD_W + WGT_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int RES_W       = 24;
	localparam int CNT_W       = 7;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_POINT = 2'd1,
		OP_GRAD  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [0:0] REG_POINT_COUNT = 1'b0;

endpackage

`default_nettype wire

/* hdl/crse_bank.sv */
`timescale 1ns / 1ps
`default_nettype none

module crse_bank (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [crse_pkg::BANK_AW-1:0]  waddr,
	input  wire logic [crse_pkg::ENTRY_W-1:0]  wdata,
	input  wire logic                          re,
	input  wire logic [crse_pkg::BANK_AW-1:0]  raddr,
	output logic      [crse_pkg::ENTRY_W-1:0]  rdata
);
	import crse_pkg::*;

	logic [ENTRY_W-1:0] mem [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/catmull_rom_segment_eval_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser opcode, tdata index, x, y, t
// m_*       out  m_tvalid/m_tready   tuser status, tdata result x, y
// apb       in   psel/penable        point_count at byte address 0
//
// one item per cycle sustained while m_tready allows; an evaluation passes
// stages s1 to s6, then the output register. points sit in four banks split
// on index bits 1:0, so the four points of a segment are read in the same cycle.
// reset clears the pipeline valids and sets point_count to 4.
// a stall on m_tready holds the whole pipeline and drops s_tready.

module catmull_rom_segment_eval_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // item_index, coord_x, coord_y, t_param, pad
	input  wire logic [1:0]  s_tuser,   // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // result_x, result_y
	output logic             m_tuser,   // status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import crse_pkg::*;

	logic                     en, acc;
	op_t                      op;
	logic [IDX_W-1:0]         idx;
	logic [T_W-1:0]           tp;
	logic [CNT_W-1:0]         pc_q, cnt_eff;
	logic                     bad;
	logic [ENTRY_W-1:0]       rd [BANKS];

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                     g_s1, g_s2, g_s3;
	logic                     bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6;
	logic [BANK_SEL_W-1:0]    sh_s1;
	logic [T_W-1:0]           t_s1, t_s2, t_s3;
	logic [TT_W-1:0]          tt_s2, tt_s3;
	logic [TTT_W-1:0]         ttt_s3;
	logic signed [COORD_W-1:0] px_s2 [BANKS], py_s2 [BANKS];
	logic signed [COORD_W-1:0] px_s3 [BANKS], py_s3 [BANKS];
	logic signed [COORD_W-1:0] px_s4 [BANKS], py_s4 [BANKS];
	logic signed [WGT_W-1:0]  w_s4 [BANKS];
	logic signed [PROD_W-1:0] prx_s5 [BANKS], pry_s5 [BANKS];
	logic signed [SUM_W-1:0]  sx_s6, sy_s6;
	logic [2*T_W-1:0]         sq;
	logic [TT_W+T_W-1:0]      cu;
	logic signed [WGT_W-1:0]  tw, ttw, tttw, w [BANKS];
	logic signed [SUM_W-1:0]  rx, ry;
	logic                     out_valid_q;
	logic [RES_W-1:0]         res_x_q, res_y_q;
	logic                     status_q;

	localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(1 << T_FRAC_BITS);
	localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1 << T_FRAC_BITS);
	localparam logic signed [SUM_W-1:0] SMAX  = SUM_W'((1 << (RES_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SMIN  = -SUM_W'(1 << (RES_W - 1));

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign op       = op_t'(s_tuser);
	assign idx      = s_tdata[5:0];
	assign tp       = s_tdata[54:38];

	// apb
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_POINT_COUNT) begin
			prdata = {25'd0, pc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= CNT_W'(4);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POINT_COUNT) begin
			pc_q <= pwdata[CNT_W-1:0];
		end
	end

	assign cnt_eff = (pc_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pc_q;
	assign bad     = (cnt_eff < CNT_W'(4)) || ((CNT_W'(idx) + CNT_W'(3)) >= cnt_eff);

	// point banks: bank b holds indexes with low bits b
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [BANK_SEL_W-1:0] off;
		logic [IDX_W-1:0]      p;
		assign off = BANK_SEL_W'(b) - idx[BANK_SEL_W-1:0];
		assign p   = idx + IDX_W'(off);
		crse_bank u_bank (
			.clk   (clk),
			.we    (acc && op == OP_WRITE && idx[BANK_SEL_W-1:0] == BANK_SEL_W'(b)),
			.waddr (idx[IDX_W-1:BANK_SEL_W]),
			.wdata ({s_tdata[37:22], s_tdata[21:6]}),
			.re    (acc),
			.raddr (p[IDX_W-1:BANK_SEL_W]),
			.rdata (rd[b])
		);
	end

	assign sq = t_s1 * t_s1;
	assign cu = tt_s2 * t_s2;

	assign tw   = WGT_W'(t_s3);
	assign ttw  = WGT_W'(tt_s3);
	assign tttw = WGT_W'(ttt_s3);

	always_comb begin
		if (g_s3) begin
			w[0] = -WGT_W'(3) * ttw + WGT_W'(4) * tw - ONE_W;
			w[1] = WGT_W'(9) * ttw - WGT_W'(10) * tw;
			w[2] = -WGT_W'(9) * ttw + WGT_W'(8) * tw + ONE_W;
			w[3] = WGT_W'(3) * ttw - WGT_W'(2) * tw;
		end else begin
			w[0] = -tttw + WGT_W'(2) * ttw - tw;
			w[1] = WGT_W'(3) * tttw - WGT_W'(5) * ttw + WGT_W'(2) * ONE_W;
			w[2] = -WGT_W'(3) * tttw + WGT_W'(4) * ttw + tw;
			w[3] = tttw - ttw;
		end
	end

	// round half up then drop the extra halving bit
	assign rx = (sx_s6 + RND) >>> (T_FRAC_BITS + 1);
	assign ry = (sy_s6 + RND) >>> (T_FRAC_BITS + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= acc && (op == OP_POINT || op == OP_GRAD);
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1   <= (op == OP_GRAD);
			bad_s1 <= bad;
			sh_s1  <= idx[BANK_SEL_W-1:0];
			t_s1   <= tp;

			g_s2   <= g_s1;
			bad_s2 <= bad_s1;
			t_s2   <= t_s1;
			tt_s2  <= TT_W'((sq + (2*T_W)'(1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
			for (int k = 0; k < BANKS; k++) begin
				px_s2[k] <= rd[BANK_SEL_W'(k) + sh_s1][COORD_W-1:0];
				py_s2[k] <= rd[BANK_SEL_W'(k) + sh_s1][ENTRY_W-1:COORD_W];
			end

			g_s3   <= g_s2;
			bad_s3 <= bad_s2;
			t_s3   <= t_s2;
			tt_s3  <= tt_s2;
			ttt_s3 <= TTT_W'((cu + (TT_W+T_W)'(1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
			px_s3  <= px_s2;
			py_s3  <= py_s2;

			bad_s4 <= bad_s3;
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			w_s4   <= w;

			bad_s5 <= bad_s4;
			for (int k = 0; k < BANKS; k++) begin
				prx_s5[k] <= PROD_W'(px_s4[k]) * PROD_W'(w_s4[k]);
				pry_s5[k] <= PROD_W'(py_s4[k]) * PROD_W'(w_s4[k]);
			end

			bad_s6 <= bad_s5;
			sx_s6  <= SUM_W'(prx_s5[0]) + SUM_W'(prx_s5[1]) + SUM_W'(prx_s5[2])
				+ SUM_W'(prx_s5[3]);
			sy_s6  <= SUM_W'(pry_s5[0]) + SUM_W'(pry_s5[1]) + SUM_W'(pry_s5[2])
				+ SUM_W'(pry_s5[3]);

			status_q <= bad_s6;
			if (bad_s6) begin
				res_x_q <= '0;
				res_y_q <= '0;
			end else begin
				res_x_q <= (rx > SMAX) ? SMAX[RES_W-1:0] :
					(rx < SMIN) ? SMIN[RES_W-1:0] : rx[RES_W-1:0];
				res_y_q <= (ry > SMAX) ? SMAX[RES_W-1:0] :
					(ry < SMIN) ? SMIN[RES_W-1:0] : ry[RES_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_y_q, res_x_q};
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

/* test/crse_checker.sv */
`timescale 1ns / 1ps

module crse_checker
	import crse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [55:0] s_tdata,   // item_index, coord_x, coord_y, t_param, pad
	input  wire logic [1:0]  s_tuser,   // opcode
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,   // result_x, result_y
	input  wire logic        m_tuser,   // status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               curves_pending
);

	typedef struct packed {
		logic signed [RES_W-1:0] res_x;
		logic signed [RES_W-1:0] res_y;
		logic                    status;
	} curve_res_t;

	logic signed [COORD_W-1:0] px_mem [MAX_POINTS];
	logic signed [COORD_W-1:0] py_mem [MAX_POINTS];
	logic [CNT_W-1:0]          count_reg;
	curve_res_t                curve_q [$];

	function automatic longint round_half_up(longint a, int s);
		return (a + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [RES_W-1:0] clamp_res(longint v);
		if (v > 64'sd8388607)
			v = 64'sd8388607;
		if (v < -64'sd8388608)
			v = -64'sd8388608;
		return v[RES_W-1:0];
	endfunction

	function automatic curve_res_t eval_curve(op_t op, logic [IDX_W-1:0] seg, logic [T_W-1:0] tp);
		curve_res_t r;
		longint     one, t, tt, ttt, sx, sy;
		longint     w [4];
		int         cnt, p;
		one = longint'(1) <<< T_FRAC_BITS;
		cnt = (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
		r = '0;
		if (cnt < 4 || int'(seg) + 3 >= cnt) begin
			r.status = 1'b1;
			return r;
		end
		t = longint'(tp);
		tt = round_half_up(t * t, T_FRAC_BITS);
		ttt = round_half_up(tt * t, T_FRAC_BITS);
		if (op == OP_POINT) begin
			w[0] = -ttt + 2 * tt - t;
			w[1] = 3 * ttt - 5 * tt + 2 * one;
			w[2] = -3 * ttt + 4 * tt + t;
			w[3] = ttt - tt;
		end else begin
			w[0] = -3 * tt + 4 * t - one;
			w[1] = 9 * tt - 10 * t;
			w[2] = -9 * tt + 8 * t + one;
			w[3] = 3 * tt - 2 * t;
		end
		sx = 0;
		sy = 0;
		for (int k = 0; k < 4; k++) begin
			p = (int'(seg) + k) % MAX_POINTS;
			sx += longint'(px_mem[p]) * w[k];
			sy += longint'(py_mem[p]) * w[k];
		end
		r.res_x = clamp_res(round_half_up(sx, T_FRAC_BITS + 1));
		r.res_y = clamp_res(round_half_up(sy, T_FRAC_BITS + 1));
		return r;
	endfunction

	initial begin
		fail_count = 0;
		curves_pending = 0;
		count_reg = 7'd4;
		for (int i = 0; i < MAX_POINTS; i++) begin
			px_mem[i] = '0;
			py_mem[i] = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		curve_res_t got, want;
		op_t        op;
		if (!arst_n) begin
			count_reg = 7'd4;
			curve_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.res_x = m_tdata[23:0];
				got.res_y = m_tdata[47:24];
				got.status = m_tuser;
				if (curve_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer x=%0d y=%0d status=%0d",
							got.res_x, got.res_y, got.status);
				end else begin
					want = curve_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
								want.res_x, want.res_y, want.status,
								got.res_x, got.res_y, got.status);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tuser);
				case (op)
					OP_WRITE: begin
						px_mem[s_tdata[5:0]] = s_tdata[21:6];
						py_mem[s_tdata[5:0]] = s_tdata[37:22];
					end
					OP_POINT, OP_GRAD: begin
						curve_q.push_back(eval_curve(op, s_tdata[5:0], s_tdata[54:38]));
					end
					default: ;
				endcase
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_POINT_COUNT)
				count_reg = pwdata[CNT_W-1:0];
		end
		curves_pending = curve_q.size();
	end

endmodule

/* test/tb_catmull_rom_segment_eval_core.sv */
`timescale 1ns / 1ps

module tb_catmull_rom_segment_eval_core;
	import crse_pkg::*;

	localparam int  CYCLE_LIMIT   = 600000;
	localparam int  DRAIN_CYCLES  = 16;
	localparam logic [2:0] ADDR_COUNT  = {REG_POINT_COUNT, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          curves_pending;
	int          cycle_cnt = 0;
	int          cur_count = 4;
	bit          long_hold = 1'b0;
	bit          steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	catmull_rom_segment_eval_core dut (.*);

	crse_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end
			m_tready <= steady ? 1'b1 : (gap_len() == 0);
		end
	end

	task automatic send_item(op_t op, int idx, int x, int y, int t);
		int g;
		s_tuser <= op;
		s_tdata <= {1'b0, t[16:0], y[15:0], x[15:0], idx[5:0]};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (curves_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_COUNT)
			cur_count = value & 32'h7f;
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int rand_t();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65536;
			2, 3: return $urandom_range(0, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	task automatic random_phase(int n);
		int r, eff, idx;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			eff = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
			if (eff >= 4 && $urandom_range(0, 9) != 0)
				idx = $urandom_range(0, eff - 4);
			else
				idx = $urandom_range(0, 63);
			if (r < 20)
				send_item(OP_WRITE, $urandom_range(0, 63), rand_coord(), rand_coord(), rand_t());
			else if (r < 58)
				send_item(OP_POINT, idx, rand_coord(), rand_coord(), rand_t());
			else if (r < 96)
				send_item(OP_GRAD, idx, rand_coord(), rand_coord(), rand_t());
			else
				send_item(OP_NONE, idx, rand_coord(), rand_coord(), rand_t());
		end
	endtask

	initial begin
		int phase_counts [6];
		phase_counts = '{64, 127, 3, 0, 4, 64};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every entry so no unwritten point is ever read
		for (int i = 0; i < MAX_POINTS; i++)
			send_item(OP_WRITE, i, rand_coord(), rand_coord(), 0);

		// directed part at the reset count of four
		send_item(OP_POINT, 0, 0, 0, 0);
		send_item(OP_POINT, 0, 0, 0, 65536);
		send_item(OP_GRAD, 0, 0, 0, 0);
		send_item(OP_GRAD, 0, 0, 0, 65536);
		send_item(OP_POINT, 1, 0, 0, 32768);
		send_item(OP_NONE, 0, 0, 0, 0);
		for (int i = 0; i < 4; i++)
			send_item(OP_WRITE, i, (i % 2) ? -32768 : 32767, (i % 2) ? 32767 : -32768, 0);
		send_item(OP_POINT, 0, 0, 0, 131071);
		send_item(OP_GRAD, 0, 0, 0, 131071);
		send_item(OP_GRAD, 0, 0, 0, 1);
		wait_idle();
		apb_write(ADDR_UNUSED, 5);
		send_item(OP_POINT, 1, 0, 0, 100);
		wait_idle();
		apb_write(ADDR_COUNT, 64);
		send_item(OP_POINT, 60, 0, 0, 40000);
		send_item(OP_GRAD, 61, 0, 0, 40000);
		send_item(OP_POINT, 63, 0, 0, 1);
		send_item(OP_WRITE, 63, 32767, 32767, 0);
		send_item(OP_GRAD, 60, 0, 0, 65535);

		// receiver holds off while the sender keeps offering
		long_hold = 1'b1;
		random_phase(100);
		// sender pauses until everything has drained
		wait_idle();

		foreach (phase_counts[p]) begin
			apb_write(ADDR_COUNT, phase_counts[p]);
			steady = (p == 1);
			random_phase(200);
			wait_idle();
			apb_write(ADDR_COUNT, $urandom_range(4, 64));
			random_phase(70);
			wait_idle();
		end
		steady = 1'b0;

		wait_idle();
		if (fail_count == 0 && curves_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
hdl/crse_pkg.sv
hdl/crse_bank.sv
hdl/catmull_rom_segment_eval_core.sv
test/crse_checker.sv
test/tb_catmull_rom_segment_eval_core.sv
